// ===== rtl/core/itoa_pkg.sv =====
// Shared constants and helpers for the integer to ASCII radix converter.
// Used by integer_to_ascii_radix and itoa_divider; depends on nothing else.
package itoa_pkg;

    // Default width of the converted integer.
    localparam int DEFAULT_VALUE_WIDTH = 32;

    // Width of the base field and of one digit value.
    localparam int RADIX_WIDTH = 6;

    // Width of one ASCII character.
    localparam int CHAR_WIDTH = 8;

    // Smallest and largest usable base, and the base that replaces an out-of-range one.
    localparam logic [RADIX_WIDTH-1:0] BASE_MIN     = 6'd2;
    localparam logic [RADIX_WIDTH-1:0] BASE_MAX     = 6'd36;
    localparam logic [RADIX_WIDTH-1:0] BASE_DEFAULT = 6'd10;

    // Character codes.
    localparam logic [CHAR_WIDTH-1:0] DIGIT_OFFSET  = 8'h30;        // '0'
    localparam logic [CHAR_WIDTH-1:0] LETTER_OFFSET = 8'h41 - 8'd10; // 'A' - 10
    localparam logic [CHAR_WIDTH-1:0] MINUS_CHAR    = 8'h2D;        // '-'

    // Map a digit value to its ASCII character: 0-9 then A-Z.
    function automatic logic [CHAR_WIDTH-1:0] ascii_of(input logic [RADIX_WIDTH-1:0] digit);
        logic [CHAR_WIDTH-1:0] wide_digit;
        wide_digit = CHAR_WIDTH'(digit);
        if (digit > RADIX_WIDTH'(9))
        begin
            return wide_digit + LETTER_OFFSET;
        end
        return wide_digit + DIGIT_OFFSET;
    endfunction

endpackage

// ===== rtl/core/itoa_divider.sv =====
// Bit-serial restoring divider: unsigned dividend by a narrow divisor.
// Depends on itoa_pkg for the divisor width.
module itoa_divider #(
    parameter int VALUE_WIDTH = itoa_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [VALUE_WIDTH-1:0]            dividend,
    input  logic [itoa_pkg::RADIX_WIDTH-1:0]  divisor,
    output logic                              done,
    output logic [VALUE_WIDTH-1:0]            quotient,
    output logic [itoa_pkg::RADIX_WIDTH-1:0]  remainder
);
    import itoa_pkg::*;

    localparam int STEP_W = $clog2(VALUE_WIDTH);

    logic                   busy_reg;
    logic                   done_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [VALUE_WIDTH-1:0] quo_reg;
    logic [RADIX_WIDTH-1:0] rem_reg;
    logic [RADIX_WIDTH-1:0] div_reg;

    logic [RADIX_WIDTH:0]   trial;
    logic [RADIX_WIDTH:0]   diff;
    logic                   take;
    logic [RADIX_WIDTH-1:0] rem_next;

    // One quotient bit per cycle: shift in the next dividend bit and try a subtract.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[VALUE_WIDTH-1]};
        diff     = trial - {1'b0, div_reg};
        take     = (trial >= {1'b0, div_reg});
        rem_next = take ? diff[RADIX_WIDTH-1:0] : trial[RADIX_WIDTH-1:0];
    end

    // Control state of the iteration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(VALUE_WIDTH - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[VALUE_WIDTH-2:0], take};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/core/integer_to_ascii_radix.sv =====
// Top level of the integer to ASCII converter in bases 2 to 36.
// Depends on itoa_pkg and itoa_divider.

// Each input transfer carries a two's complement value and a base; a base outside
// 2..36 means base 10. The block sends the ASCII digits most significant first
// ('0'-'9', then 'A'-'Z'), with tlast on the final character; zero gives "0".
// Only in base 10 is a negative value printed as '-' and its magnitude; other
// bases print the raw unsigned bit pattern. Digits are produced least significant
// first by a bit-serial divider, kept in a small synchronous digit memory and read
// back in reverse through the read and load states. One item is converted at a
// time; a new one is accepted once the last character sits in the output register.
module integer_to_ascii_radix #(
    parameter int VALUE_WIDTH = itoa_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic clk,
    input  logic rst_n,

    // Input stream.
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // Fields from bit 0 up: value (VALUE_WIDTH, signed), radix (6), zero padding.
    input  logic [((VALUE_WIDTH + itoa_pkg::RADIX_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,

    // Output stream.
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // Fields from bit 0 up: character (8).
    output logic [itoa_pkg::CHAR_WIDTH-1:0] m_axis_tdata,
    output logic m_axis_tlast
);
    import itoa_pkg::*;

    localparam int IDX_W = $clog2(VALUE_WIDTH);
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SIGN,
        ST_READ,
        ST_LOAD
    } state_t;

    state_t                 state_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   neg_reg;
    logic [RADIX_WIDTH-1:0] base_reg;

    logic                   out_valid_reg;
    logic [CHAR_WIDTH-1:0]  out_char_reg;
    logic                   out_last_reg;

    // Digit memory, least significant digit first.
    logic [RADIX_WIDTH-1:0] digit_mem [VALUE_WIDTH];
    logic [RADIX_WIDTH-1:0] rd_data_reg;

    logic                   in_xfer;
    logic                   out_xfer;
    logic                   slot_free;
    logic [VALUE_WIDTH-1:0] in_value;
    logic [RADIX_WIDTH-1:0] in_radix;
    logic [RADIX_WIDTH-1:0] in_base;
    logic                   in_neg;
    logic [VALUE_WIDTH-1:0] in_mag;
    logic [CNT_W-1:0]       cnt_dec;

    logic                   div_start;
    logic [VALUE_WIDTH-1:0] div_dividend;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quotient;
    logic [RADIX_WIDTH-1:0] div_remainder;

    // Handshakes and input decoding.
    always_comb
    begin
        in_xfer   = s_axis_tvalid && s_axis_tready;
        out_xfer  = out_valid_reg && m_axis_tready;
        slot_free = !out_valid_reg || m_axis_tready;
        in_value  = s_axis_tdata[VALUE_WIDTH-1:0];
        in_radix  = s_axis_tdata[VALUE_WIDTH +: RADIX_WIDTH];
        in_base   = (in_radix < BASE_MIN || in_radix > BASE_MAX) ? BASE_DEFAULT : in_radix;
        in_neg    = (in_base == BASE_DEFAULT) && in_value[VALUE_WIDTH-1];
        in_mag    = in_neg ? (VALUE_WIDTH'(0) - in_value) : in_value;
        cnt_dec   = cnt_reg - CNT_W'(1);
    end

    // Start a division on a new item, and again while the quotient is nonzero.
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = div_quotient;
        if (state_reg == ST_IDLE)
        begin
            div_start    = in_xfer;
            div_dividend = in_mag;
        end
        else if (state_reg == ST_DIVIDE)
        begin
            div_start = div_done && (div_quotient != '0);
        end
    end

    itoa_divider #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (state_reg == ST_IDLE ? in_base : base_reg),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // Digit memory: write each remainder, read back in reverse order.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DIVIDE && div_done)
        begin
            digit_mem[cnt_reg[IDX_W-1:0]] <= div_remainder;
        end
        if (state_reg == ST_READ)
        begin
            rd_data_reg <= digit_mem[cnt_dec[IDX_W-1:0]];
        end
    end

    // Sequencer and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            neg_reg       <= 1'b0;
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (out_xfer)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        neg_reg   <= in_neg;
                        base_reg  <= in_base;
                        cnt_reg   <= '0;
                        state_reg <= ST_DIVIDE;
                    end
                end

                ST_DIVIDE:
                begin
                    if (div_done)
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                        if (div_quotient == '0)
                        begin
                            state_reg <= ST_SIGN;
                        end
                    end
                end

                ST_SIGN:
                begin
                    if (!neg_reg)
                    begin
                        state_reg <= ST_READ;
                    end
                    else if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_char_reg  <= MINUS_CHAR;
                        out_last_reg  <= 1'b0;
                        state_reg     <= ST_READ;
                    end
                end

                ST_READ:
                begin
                    state_reg <= ST_LOAD;
                end

                ST_LOAD:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_char_reg  <= ascii_of(rd_data_reg);
                        out_last_reg  <= (cnt_reg == CNT_W'(1));
                        cnt_reg       <= cnt_dec;
                        state_reg     <= (cnt_reg == CNT_W'(1)) ? ST_IDLE : ST_READ;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
